// ----- rtl/lge_pkg.sv -----
// Shared constants and types for the life generation engine.
package lge_pkg;

    localparam int ROWS       = 32;
    localparam int COLS       = 64;
    localparam int ROW_IDX_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Stream field widths
    localparam int REQ_F_W    = 2;
    localparam int ROW_F_W    = 5;
    localparam int COL_F_W    = 6;
    localparam int CELLS_F_W  = 64;
    localparam int GEN_W      = 32;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 104;
    localparam int OUT_PAD_W  = OUT_W - (ROW_F_W + CELLS_F_W + GEN_W);

    // Rule B3/S23 neighbor counts
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] SURVIVE_LOW = 4'd2;

    typedef enum logic [REQ_F_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_TOGGLE = 2'd1,
        REQ_STEP   = 2'd2
    } t_req;

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } t_state;

    // Control shared by every row cell of the chain
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctl;

endpackage

// ----- rtl/lge_row_cell.sv -----
// One grid row held in the cell chain; shifts toward row zero during a step.
module lge_row_cell import lge_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  logic            i_toggle,
    input  logic [COLS-1:0] i_mask,
    input  logic [COLS-1:0] i_from_next,
    output logic [COLS-1:0] o_row
);

    logic [COLS-1:0] r_row;
    logic [COLS-1:0] n_row;

    // Pick the next row: take the neighbor's row on shift, else flip the toggled cell
    always_comb begin
        n_row = r_row;
        if (i_ctl.shift) begin
            n_row = i_from_next;
        end else if (i_toggle) begin
            n_row = r_row ^ i_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_row = r_row;

endmodule

// ----- rtl/lge_rule_unit.sv -----
// Next-generation row from a three-row window by rule B3/S23.
module lge_rule_unit import lge_pkg::*; (
    input  logic [COLS-1:0] i_above,
    input  logic [COLS-1:0] i_here,
    input  logic [COLS-1:0] i_below,
    output logic [COLS-1:0] o_next
);

    logic [COLS+1:0] w_a;
    logic [COLS+1:0] w_h;
    logic [COLS+1:0] w_b;
    logic [3:0]      w_cnt [COLS];

    // Pad with dead cells past both edges
    assign w_a = {1'b0, i_above, 1'b0};
    assign w_h = {1'b0, i_here,  1'b0};
    assign w_b = {1'b0, i_below, 1'b0};

    // Count the eight neighbors of each column and apply the rule
    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            w_cnt[c] = 4'(w_a[c]) + 4'(w_a[c+1]) + 4'(w_a[c+2])
                     + 4'(w_h[c])                + 4'(w_h[c+2])
                     + 4'(w_b[c]) + 4'(w_b[c+1]) + 4'(w_b[c+2]);
            if (i_here[c]) begin
                o_next[c] = (w_cnt[c] == SURVIVE_LOW) || (w_cnt[c] == BIRTH_COUNT);
            end else begin
                o_next[c] = (w_cnt[c] == BIRTH_COUNT);
            end
        end
    end

endmodule

// ----- rtl/life_generation_engine_top.sv -----
// Top level of the life generation engine: request stream in, row stream out.
//
// Requests arrive on the s_axis group; tdata holds req_type, cell_row and
// cell_col. Results leave on the m_axis group; tdata holds row_index,
// row_cells and generation, tlast marks the final row of a request.
// The grid lives in a chain of ROWS row cells. A clear empties the grid and
// the generation counter in the cycle it is taken and gives no result. A
// toggle of an in-range cell flips that cell in the cycle it is taken and
// puts that row in the output register, so it shows in the next cycle; an
// out-of-range toggle is taken but does nothing. A step shifts the chain
// toward row zero once per cycle while the output register is free or being
// drained; the rule unit sees the row leaving the chain, the row before it
// and the row behind it, and its result enters the far end of the chain and
// the output register. A step walks all ROWS rows of the chain in turn.
// A new request is taken only between steps and only when the output
// register is free or being drained. When the receiver stalls, the step
// pauses with the chain frozen and resumes when tready returns.
// Reset empties the grid, zeroes the counter and drops any pending result.
module life_generation_engine_top import lge_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // s_axis tdata: req_type[1:0], cell_row[6:2], cell_col[12:7], zero fill
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,
    // m_axis tdata: row_index[4:0], row_cells[68:5], generation[100:69], zero fill
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,
    output logic             o_m_tlast
);

    t_state                 r_state;
    t_state                 n_state;
    logic [ROW_IDX_W-1:0]   r_step_row;
    logic [COLS-1:0]        r_above;
    logic [GEN_W-1:0]       r_gen;
    logic                   r_out_valid;
    logic [ROW_F_W-1:0]     r_out_idx;
    logic [CELLS_F_W-1:0]   r_out_cells;
    logic [GEN_W-1:0]       r_out_gen;
    logic                   r_out_last;

    t_req                   w_req;
    logic [ROW_F_W-1:0]     w_in_row;
    logic [COL_F_W-1:0]     w_in_col;
    logic                   w_slot;
    logic                   w_acc;
    logic                   w_adv;
    logic                   w_in_range;
    logic                   w_tgl_ok;
    logic                   w_step_last;
    t_cell_ctl              w_ctl;
    logic [ROW_IDX_W-1:0]   w_sel;
    logic [COLS-1:0]        w_mask;
    logic [COLS-1:0]        w_tgl_row;
    logic [COLS-1:0]        w_below;
    logic [COLS-1:0]        w_new_row;
    logic [COLS-1:0]        w_row [ROWS];

    // Unpack the request
    assign w_req      = t_req'(i_s_tdata[REQ_F_W-1:0]);
    assign w_in_row   = i_s_tdata[REQ_F_W +: ROW_F_W];
    assign w_in_col   = i_s_tdata[REQ_F_W+ROW_F_W +: COL_F_W];
    assign w_in_range = (32'(w_in_row) < ROWS) && (32'(w_in_col) < COLS);
    assign w_sel      = ROW_IDX_W'(w_in_row);
    assign w_mask     = {{(COLS-1){1'b0}}, 1'b1} << w_in_col;
    assign w_step_last = (r_step_row == ROW_IDX_W'(ROWS-1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && (w_req == REQ_STEP)) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (w_adv && w_step_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake and chain control
    always_comb begin
        w_slot      = !r_out_valid || i_m_tready;
        o_s_tready  = (r_state == ST_IDLE) && w_slot;
        w_acc       = i_s_tvalid && o_s_tready;
        w_adv       = (r_state == ST_STEP) && w_slot;
        w_tgl_ok    = w_acc && (w_req == REQ_TOGGLE) && w_in_range;
        w_ctl.clear = w_acc && (w_req == REQ_CLEAR);
        w_ctl.shift = w_adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Chain of row cells; the far end takes the freshly computed row
    for (genvar i = 0; i < ROWS; i++) begin : g_cell
        logic [COLS-1:0] w_from_next;
        if (i == ROWS-1) begin : g_tail
            assign w_from_next = w_new_row;
        end else begin : g_body
            assign w_from_next = w_row[i+1];
        end
        lge_row_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_toggle    (w_tgl_ok && (w_sel == ROW_IDX_W'(i))),
            .i_mask      (w_mask),
            .i_from_next (w_from_next),
            .o_row       (w_row[i])
        );
    end

    // Window: row leaving the chain, the one before, the one behind
    assign w_below = w_step_last ? '0 : w_row[(ROWS > 1) ? 1 : 0];

    lge_rule_unit u_rule (
        .i_above (r_above),
        .i_here  (w_row[0]),
        .i_below (w_below),
        .o_next  (w_new_row)
    );

    assign w_tgl_row = w_row[w_sel] ^ w_mask;

    // Step bookkeeping: row counter, window row and generation counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_row <= '0;
            r_above    <= '0;
            r_gen      <= '0;
        end else begin
            if (w_acc && (w_req == REQ_STEP)) begin
                r_step_row <= '0;
                r_above    <= '0;
            end else if (w_adv) begin
                r_step_row <= r_step_row + 1'b1;
                r_above    <= w_row[0];
            end
            if (w_ctl.clear) begin
                r_gen <= '0;
            end else if (w_adv && w_step_last) begin
                r_gen <= r_gen + 1'b1;
            end
        end
    end

    // Output register: hold until taken, load from the step or a toggle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv || w_tgl_ok) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_idx   <= ROW_F_W'(r_step_row);
            r_out_cells <= CELLS_F_W'(w_new_row);
            r_out_gen   <= r_gen + 1'b1;
            r_out_last  <= w_step_last;
        end else if (w_tgl_ok) begin
            r_out_idx   <= w_in_row;
            r_out_cells <= CELLS_F_W'(w_tgl_row);
            r_out_gen   <= r_gen;
            r_out_last  <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out_gen, r_out_cells, r_out_idx};

endmodule

// ----- rtl/lge_checker.sv -----
// Port-level checks for the life generation engine, bound to the top level.
module lge_checker import lge_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,
    input  logic             o_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] o_m_tdata,
    input  logic             o_m_tlast
);

    // Drop any pending result at reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result pending right after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // Take a request only with room for its result
    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !o_m_tvalid || i_m_tready)
        else $error("request taken while result blocked");

    // Stay busy after a step request
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tdata[REQ_F_W-1:0] == REQ_STEP) |=> !o_s_tready)
        else $error("step request did not block the input");

    // Send the rows of a step back to back while the receiver takes them
    a_mid_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("gap in the middle of a step");

endmodule

bind life_generation_engine_top lge_checker u_lge_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
